// ----- src/bb3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// types and constants shared by the 3x3 box blur
// ----------------------------------------------------------------------------
package bb3_pkg;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_READ  = 3'd1,
        ST_ACC   = 3'd2,
        ST_DIV   = 3'd3,
        ST_OUT   = 3'd4
    } state_t;

    localparam int unsigned PIX_W  = 24;
    localparam int unsigned SUM_W  = 12;
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

endpackage

// ----- src/box_blur_3x3_edge_aware.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware
// streaming 3x3 box blur with edge-aware averaging over three line banks
// ----------------------------------------------------------------------------
// channel   direction  signals
// s_        in         s_valid s_ready s_action s_in_red s_in_green s_in_blue
// m_        out        m_valid m_ready m_out_red m_out_green m_out_blue
//                      m_run_last m_frame_last
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data
//
// one transaction: the pixel is stored, then for each result the nine line memory
// reads run (one port, one word a cycle), the last sum is added, the sums
// settle, restoring division runs (load, 8 steps, 1 spare) and the result is
// handed over; up to two results, then back to idle; the read port paces it.
// reset clears the state, position counters and valid flags; n_reg, the data
// registers and the line memory are not cleared.
// a stalled result holds the block; input is taken again once it leaves.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [7:0]  s_in_red,
    input  logic [7:0]  s_in_green,
    input  logic [7:0]  s_in_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic        m_run_last,
    output logic        m_frame_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW = $clog2(3 * MAX_WIDTH);
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int XW = CW + 2;

    logic [bb3_pkg::PIX_W-1:0] mem [DEPTH];
    logic [bb3_pkg::PIX_W-1:0] rd_data_reg;

    bb3_pkg::state_t state_reg, state_next;

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [XW-1:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [XW-1:0] drain_reg, drain_next;
    logic done_reg, done_next;
    logic [1:0] bank_reg, bank_next;   // row_reg mod 3

    // pending result jobs
    logic        job_valid_reg [2];
    logic [XW-1:0] job_col_reg [2];
    logic [1:0]  job_bank_reg  [2];
    logic        job_up_reg    [2];
    logic        job_down_reg  [2];
    logic        job_right_reg [2];
    logic        job_flast_reg [2];
    logic        job_last_reg  [2];
    logic        job_sel_reg;

    logic [3:0] tap_reg;           // 0..8 issue, then accumulate lag
    logic       rd_en_reg;
    logic       rd_use_reg;
    logic [bb3_pkg::SUM_W-1:0] sum_reg [3];
    logic [3:0] n_reg;
    logic [bb3_pkg::SUM_W+1:0] rem_reg [3];
    logic [7:0] quo_reg [3];
    logic [3:0] div_cnt_reg;

    logic [7:0] o_r_reg, o_g_reg, o_b_reg;
    logic o_last_reg, o_flast_reg, o_valid_reg;

    logic [XW-1:0] w_eff;
    always_comb begin
        if (width_reg == 11'd0)
            w_eff = XW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = XW'(width_reg);
    end
    logic [15:0] h_eff;
    assign h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == bb3_pkg::ST_IDLE) && !o_valid_reg;
    assign m_valid = o_valid_reg;
    assign m_out_red = o_r_reg;
    assign m_out_green = o_g_reg;
    assign m_out_blue = o_b_reg;
    assign m_run_last = o_last_reg;
    assign m_frame_last = o_flast_reg;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 11'd1024;
            height_reg <= 16'd1;
        end else if (cfg_valid) begin
            if (cfg_index == bb3_pkg::CFG_IMAGE_WIDTH)
                width_reg <= cfg_data[10:0];
            else if (cfg_index == bb3_pkg::CFG_IMAGE_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // current job and its tap
    logic        cur;
    logic [1:0]  tr, tc;
    logic        tap_ok;
    logic [1:0]  tap_bank;
    logic [XW-1:0] tap_col;
    assign cur = job_sel_reg;
    always_comb begin
        if (tap_reg inside {[4'd0:4'd2]})
            tr = 2'd0;
        else if (tap_reg inside {[4'd3:4'd5]})
            tr = 2'd1;
        else
            tr = 2'd2;
        if (tap_reg inside {4'd0, 4'd3, 4'd6})
            tc = 2'd0;
        else if (tap_reg inside {4'd1, 4'd4, 4'd7})
            tc = 2'd1;
        else
            tc = 2'd2;
    end
    always_comb begin
        tap_ok = 1'b1;
        if (tr == 2'd0 && !job_up_reg[cur]) tap_ok = 1'b0;
        if (tr == 2'd2 && !job_down_reg[cur]) tap_ok = 1'b0;
        if (tc == 2'd0 && job_col_reg[cur] == '0) tap_ok = 1'b0;
        if (tc == 2'd2 && !job_right_reg[cur]) tap_ok = 1'b0;
        case (tr)
            2'd0: tap_bank = (job_bank_reg[cur] == 2'd0) ? 2'd2 : job_bank_reg[cur] - 2'd1;
            2'd2: tap_bank = (job_bank_reg[cur] == 2'd2) ? 2'd0 : job_bank_reg[cur] + 2'd1;
            default: tap_bank = job_bank_reg[cur];
        endcase
        tap_col = job_col_reg[cur] + XW'(tc) - XW'(1);
    end

    logic [AW-1:0] rd_addr;
    assign rd_addr = AW'(tap_bank) * AW'(MAX_WIDTH) + AW'(tap_col);

    // store write
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [XW-1:0] col_next_pre;
    logic [15:0] row_pre;
    logic [1:0] bank_pre;
    assign col_next_pre = done_reg ? '0 : col_reg;
    assign row_pre = done_reg ? 16'd0 : row_reg;
    assign bank_pre = done_reg ? 2'd0 : bank_reg;
    assign wr_en = s_fire && (s_action == bb3_pkg::ACT_PIXEL) &&
                   (col_next_pre < XW'(MAX_WIDTH));
    assign wr_addr = AW'(bank_pre) * AW'(MAX_WIDTH) + AW'(col_next_pre[CW-1:0]);

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_addr] <= {s_in_red, s_in_green, s_in_blue};
        if (state_reg == bb3_pkg::ST_READ && tap_reg < 4'd9)
            rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bb3_pkg::ST_IDLE: begin
                if (s_fire) state_next = bb3_pkg::ST_READ;
            end
            bb3_pkg::ST_READ: begin
                if (!job_valid_reg[cur]) state_next = bb3_pkg::ST_IDLE;
                else if (tap_reg == 4'd9) state_next = bb3_pkg::ST_ACC;
            end
            bb3_pkg::ST_ACC: state_next = bb3_pkg::ST_DIV;
            bb3_pkg::ST_DIV: begin
                if (div_cnt_reg == 4'd0) state_next = bb3_pkg::ST_OUT;
            end
            bb3_pkg::ST_OUT: begin
                if (!o_valid_reg) state_next = bb3_pkg::ST_READ;
            end
            default: state_next = bb3_pkg::ST_IDLE;
        endcase
    end

    // job setup for an accepted transaction
    logic        nj_v [2];
    logic [XW-1:0] nj_c [2];
    logic        nj_up, nj_right0, nj_flast, nj_last0;
    logic        row_end;
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        drain_next = drain_reg;
        done_next = done_reg;
        bank_next = bank_reg;
        nj_v[0] = 1'b0; nj_v[1] = 1'b0;
        nj_c[0] = '0; nj_c[1] = '0;
        nj_up = 1'b0; nj_right0 = 1'b1; nj_flast = 1'b0; nj_last0 = 1'b0;
        row_end = 1'b0;
        if (s_action == bb3_pkg::ACT_DRAIN) begin
            if (done_reg) begin
                nj_v[0] = 1'b1;
                nj_c[0] = drain_reg;
                nj_up = row_reg != 16'd0;
                nj_right0 = (drain_reg + XW'(1)) < w_eff;
                nj_flast = drain_reg >= w_eff - XW'(1);
                nj_last0 = 1'b1;
                if (nj_flast) begin
                    done_next = 1'b0; row_next = 16'd0; bank_next = 2'd0;
                    drain_next = '0;
                end else begin
                    drain_next = drain_reg + XW'(1);
                end
            end
        end else begin
            done_next = 1'b0;
            row_end = col_next_pre >= w_eff - XW'(1);
            nj_up = row_pre > 16'd1;
            if (row_pre != 16'd0) begin
                nj_v[0] = col_next_pre != '0;
                nj_c[0] = col_next_pre - XW'(1);
                nj_v[1] = row_end;
                nj_c[1] = col_next_pre;
                nj_last0 = !row_end;
            end
            if (row_end) begin
                col_next = '0;
                if (row_pre >= h_eff - 16'd1) begin
                    done_next = 1'b1;
                    drain_next = '0;
                    row_next = row_pre;
                    bank_next = bank_pre;
                end else begin
                    row_next = row_pre + 16'd1;
                    bank_next = (bank_pre == 2'd2) ? 2'd0 : bank_pre + 2'd1;
                end
            end else begin
                col_next = col_next_pre + XW'(1);
                row_next = row_pre;
                bank_next = bank_pre;
                drain_next = done_reg ? '0 : drain_reg;
            end
        end
    end

    // pixel row r-1 lives in the bank before bank_pre
    logic [1:0] prev_bank;
    assign prev_bank = (bank_pre == 2'd0) ? 2'd2 : bank_pre - 2'd1;

    // division step: rem holds 2*sum+n, divisor 2*n
    logic [4:0] dvs;
    assign dvs = {n_reg, 1'b0};

    logic [bb3_pkg::SUM_W+1:0] num [3];
    always_comb begin
        for (int k = 0; k < 3; k++)
            num[k] = {1'b0, sum_reg[k], 1'b0} + (bb3_pkg::SUM_W+2)'(n_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bb3_pkg::ST_IDLE;
            col_reg <= '0; row_reg <= '0; drain_reg <= '0; done_reg <= 1'b0;
            bank_reg <= 2'd0;
            job_valid_reg[0] <= 1'b0; job_valid_reg[1] <= 1'b0;
            job_sel_reg <= 1'b0;
            tap_reg <= '0; rd_en_reg <= 1'b0; rd_use_reg <= 1'b0;
            div_cnt_reg <= '0;
            o_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (o_valid_reg && m_ready) o_valid_reg <= 1'b0;
            case (state_reg)
                bb3_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        col_reg <= col_next; row_reg <= row_next;
                        drain_reg <= drain_next; done_reg <= done_next;
                        bank_reg <= bank_next;
                        job_sel_reg <= !nj_v[0];
                        tap_reg <= '0; rd_en_reg <= 1'b0;
                        for (int k = 0; k < 2; k++) begin
                            job_valid_reg[k] <= nj_v[k];
                            job_col_reg[k] <= nj_c[k];
                            job_up_reg[k] <= nj_up;
                            job_down_reg[k] <= (s_action == bb3_pkg::ACT_PIXEL);
                            job_right_reg[k] <= (k == 0) ? nj_right0 : 1'b0;
                            job_flast_reg[k] <= nj_flast;
                            job_last_reg[k] <= (k == 0) ? nj_last0 : 1'b1;
                            job_bank_reg[k] <= (s_action == bb3_pkg::ACT_DRAIN) ?
                                               bank_reg : prev_bank;
                        end
                        for (int k = 0; k < 3; k++) sum_reg[k] <= '0;
                        n_reg <= '0;
                    end
                end
                bb3_pkg::ST_READ: begin
                    if (job_valid_reg[cur]) begin
                        rd_en_reg <= tap_ok && tap_reg < 4'd9;
                        if (rd_en_reg) begin
                            sum_reg[0] <= sum_reg[0] + bb3_pkg::SUM_W'(rd_data_reg[23:16]);
                            sum_reg[1] <= sum_reg[1] + bb3_pkg::SUM_W'(rd_data_reg[15:8]);
                            sum_reg[2] <= sum_reg[2] + bb3_pkg::SUM_W'(rd_data_reg[7:0]);
                            n_reg <= n_reg + 4'd1;
                        end
                        tap_reg <= tap_reg + 4'd1;
                    end
                end
                bb3_pkg::ST_ACC: begin
                    if (rd_en_reg) begin
                        sum_reg[0] <= sum_reg[0] + bb3_pkg::SUM_W'(rd_data_reg[23:16]);
                        sum_reg[1] <= sum_reg[1] + bb3_pkg::SUM_W'(rd_data_reg[15:8]);
                        sum_reg[2] <= sum_reg[2] + bb3_pkg::SUM_W'(rd_data_reg[7:0]);
                        n_reg <= n_reg + 4'd1;
                    end
                    rd_en_reg <= 1'b0;
                    rd_use_reg <= 1'b1;
                    div_cnt_reg <= 4'd9;
                end
                bb3_pkg::ST_DIV: begin
                    if (rd_use_reg) begin
                        rd_use_reg <= 1'b0;
                        for (int k = 0; k < 3; k++) begin
                            rem_reg[k] <= num[k];
                            quo_reg[k] <= '0;
                        end
                        div_cnt_reg <= 4'd8;
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            if (rem_reg[k] >= ((bb3_pkg::SUM_W+2)'(dvs) << (div_cnt_reg - 4'd1))) begin
                                rem_reg[k] <= rem_reg[k] -
                                    ((bb3_pkg::SUM_W+2)'(dvs) << (div_cnt_reg - 4'd1));
                                quo_reg[k] <= quo_reg[k] | (8'd1 << (div_cnt_reg - 4'd1));
                            end
                        end
                        div_cnt_reg <= div_cnt_reg - 4'd1;
                    end
                end
                bb3_pkg::ST_OUT: begin
                    if (!o_valid_reg) begin
                        o_valid_reg <= 1'b1;
                        o_r_reg <= quo_reg[0]; o_g_reg <= quo_reg[1]; o_b_reg <= quo_reg[2];
                        o_last_reg <= job_last_reg[cur];
                        o_flast_reg <= job_flast_reg[cur];
                        job_valid_reg[cur] <= 1'b0;
                        job_sel_reg <= 1'b1;
                        tap_reg <= '0; rd_en_reg <= 1'b0;
                        for (int k = 0; k < 3; k++) sum_reg[k] <= '0;
                        n_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
